FILE: rtl/core/ssm_pkg.sv
// Shared types and constants for the skid-steer track command mixer.
`default_nettype none
package ssm_pkg;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

    typedef struct packed {
        logic load_in;
        logic mix1;
        logic mix2;
        logic mix3;
        logic mul_l;
        logic mul_r;
        logic upd;
        logic tick;
        logic frame_load;
        logic frame_adv;
        logic out_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic taken;
        logic last;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: rtl/core/skid_steer_track_command_mixer.sv
// Top level of the skid-steer track command mixer.
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+-----------------------------------
//  in      | in  | i_in_valid / o_in_stall   | action, linear_mm_s, angular_mrad_s
//  out     | out | o_out_valid / i_out_stall | can_id, data bytes 0..3, last_frame
//  cfg     | in  | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  One word at a time. A velocity command steps through clamp and offset
//  multiply, reciprocal multiply for the divide by 1000, correction and mix,
//  then one shared throttle multiplier used once per track, then the update.
//  A tick updates the tick count, loads the first of five frames and advances on each take.
//  Output stall holds the current frame; the input stalls until it is done.
//  Reset restores the register defaults and clears tracks and tick count.
`default_nettype none
module skid_steer_track_command_mixer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_action,
    input  wire logic signed [15:0]              i_linear_mm_s,
    input  wire logic signed [15:0]              i_angular_mrad_s,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [28:0]                          o_can_id,
    output logic [7:0]                           o_data_byte0,
    output logic [7:0]                           o_data_byte1,
    output logic [7:0]                           o_data_byte2,
    output logic [7:0]                           o_data_byte3,
    output logic                                 o_last_frame
);
    import ssm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ssm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_linear_mm_s    (i_linear_mm_s),
        .i_angular_mrad_s (i_angular_mrad_s),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_can_id         (o_can_id),
        .o_data_byte0     (o_data_byte0),
        .o_data_byte1     (o_data_byte1),
        .o_data_byte2     (o_data_byte2),
        .o_data_byte3     (o_data_byte3),
        .o_last_frame     (o_last_frame)
    );

endmodule
`default_nettype wire

FILE: rtl/core/ssm_ctrl.sv
// Sequencer for command mixing and tick frame emission.
`default_nettype none
module ssm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_action,
    input  wire ssm_pkg::t_dp_stat i_stat,
    output logic                  o_in_stall,
    output ssm_pkg::t_dp_cmd      o_cmd
);
    import ssm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MIX1 = 9'b000000010,
        S_MIX2 = 9'b000000100,
        S_MIX3 = 9'b000001000,
        S_MULL = 9'b000010000,
        S_MULR = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_TICK = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = i_action ? S_TICK : S_MIX1;
                end
            end
            S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = S_MIX3;
            end
            S_MIX3: begin
                o_cmd.mix3 = 1'b1;
                n_state    = S_MULL;
            end
            S_MULL: begin
                o_cmd.mul_l = 1'b1;
                n_state     = S_MULR;
            end
            S_MULR: begin
                o_cmd.mul_r = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_IDLE;
            end
            S_TICK: begin
                o_cmd.tick       = 1'b1;
                o_cmd.frame_load = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.taken) begin
                    if (i_stat.last) begin
                        o_cmd.out_clear = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.frame_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ssm_dp.sv
// Datapath: registers, clamp and mix arithmetic, track state and frame output.
`default_nettype none
module ssm_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic signed [15:0]              i_linear_mm_s,
    input  wire logic signed [15:0]              i_angular_mrad_s,
    input  wire logic                            i_out_stall,
    input  wire ssm_pkg::t_dp_cmd                i_cmd,
    output ssm_pkg::t_dp_stat                    o_stat,
    output logic                                 o_out_valid,
    output logic [28:0]                          o_can_id,
    output logic [7:0]                           o_data_byte0,
    output logic [7:0]                           o_data_byte1,
    output logic [7:0]                           o_data_byte2,
    output logic [7:0]                           o_data_byte3,
    output logic                                 o_last_frame
);
    import ssm_pkg::*;

    localparam logic [17:0] RECIP_1000 = 18'd134217;
    localparam int unsigned RECIP_SH   = 27;
    localparam logic [7:0]  THR_MAX    = 8'd250;
    localparam logic [1:0]  DIR_STOP   = 2'd0;
    localparam logic [1:0]  DIR_FWD    = 2'd1;
    localparam logic [1:0]  DIR_REV    = 2'd2;

    localparam logic [2:0]  FRM_ENABLE = 3'd0;
    localparam logic [2:0]  FRM_HYDR   = 3'd1;
    localparam logic [2:0]  FRM_VALVE  = 3'd2;
    localparam logic [2:0]  FRM_LEFT   = 3'd3;
    localparam logic [2:0]  FRM_RIGHT  = 3'd4;

    localparam logic [28:0] ID_ENABLE  = 29'h201;
    localparam logic [28:0] ID_HYDR    = 29'h301;
    localparam logic [28:0] ID_VALVE   = 29'h302;
    localparam logic [28:0] ID_LEFT    = 29'h0CFE3206;
    localparam logic [28:0] ID_RIGHT   = 29'h0CFE3306;

    function automatic logic [7:0] thr_of(input logic [41:0] p, input logic zero);
        logic [25:0] t;
        t = p[41:16];
        if (zero) begin
            thr_of = 8'd0;
        end else if (t > {18'd0, THR_MAX}) begin
            thr_of = THR_MAX;
        end else if (t == 26'd0) begin
            thr_of = 8'd1;
        end else begin
            thr_of = t[7:0];
        end
    endfunction

    function automatic logic [1:0] dir_of(input logic signed [18:0] s);
        if (s == 19'sd0) begin
            dir_of = DIR_STOP;
        end else if (s[18]) begin
            dir_of = DIR_REV;
        end else begin
            dir_of = DIR_FWD;
        end
    endfunction

    logic [11:0] r_speed_lim;
    logic [11:0] r_half_sep;
    logic [14:0] r_max_turn;
    logic [23:0] r_gain;
    logic [15:0] r_timeout;

    logic signed [15:0] r_lin;
    logic signed [15:0] r_ang;
    logic signed [12:0] r_v;
    logic               r_wneg;
    logic [26:0]        r_prod;
    logic [17:0]        r_qe;
    logic signed [18:0] r_vl;
    logic signed [18:0] r_vr;
    logic [41:0]        r_pl;
    logic [41:0]        r_pr;

    logic [7:0]  r_left_thr;
    logic [1:0]  r_left_dir;
    logic [7:0]  r_right_thr;
    logic [1:0]  r_right_dir;
    logic [15:0] r_ticks;

    logic        r_out_valid;
    logic [2:0]  r_frame;
    logic [28:0] r_can_id;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [7:0]  r_b3;
    logic        r_last;

    // clamp
    logic signed [16:0] lin_x;
    logic signed [16:0] ang_x;
    logic signed [16:0] lim_v;
    logic signed [16:0] lim_w;
    logic signed [16:0] v_c;
    logic signed [16:0] w_c;
    logic signed [16:0] w_abs;

    // divide by 1000 and mix
    logic [44:0]        recip_prod;
    logic [27:0]        q1000;
    logic [27:0]        rem;
    logic [17:0]        d_mag;
    logic signed [18:0] d_s;
    logic signed [18:0] v_x;

    // throttle multiply
    logic signed [18:0] vl_abs;
    logic signed [18:0] vr_abs;
    logic [17:0]        mul_a;
    logic [41:0]        mul_p;

    // tick
    logic [15:0] n_ticks;

    // frame select
    logic [2:0]  n_frame;
    logic [28:0] f_id;
    logic [7:0]  f_b0;
    logic [7:0]  f_b1;
    logic [7:0]  f_b2;
    logic [7:0]  f_b3;
    logic        f_last;

    always_comb begin
        lin_x = {r_lin[15], r_lin};
        ang_x = {r_ang[15], r_ang};
        lim_v = $signed({5'd0, r_speed_lim});
        lim_w = $signed({2'd0, r_max_turn});
        priority if (lin_x > lim_v) begin
            v_c = lim_v;
        end else if (lin_x < -lim_v) begin
            v_c = -lim_v;
        end else begin
            v_c = lin_x;
        end
        priority if (ang_x > lim_w) begin
            w_c = lim_w;
        end else if (ang_x < -lim_w) begin
            w_c = -lim_w;
        end else begin
            w_c = ang_x;
        end
        w_abs = w_c[16] ? -w_c : w_c;
    end

    always_comb begin
        recip_prod = {18'd0, r_prod} * {27'd0, RECIP_1000};
        q1000      = {10'd0, r_qe} * 28'd1000;
        rem        = {1'b0, r_prod} - q1000;
        d_mag      = r_qe + {17'd0, (rem >= 28'd1000)};
        d_s        = r_wneg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
        v_x        = {{6{r_v[12]}}, r_v};
    end

    always_comb begin
        vl_abs = r_vl[18] ? -r_vl : r_vl;
        vr_abs = r_vr[18] ? -r_vr : r_vr;
        mul_a  = i_cmd.mul_r ? vr_abs[17:0] : vl_abs[17:0];
        mul_p  = {24'd0, mul_a} * {18'd0, r_gain};
    end

    assign n_ticks = (r_ticks != 16'hFFFF) ? (r_ticks + 16'd1) : r_ticks;

    always_comb begin
        n_frame = i_cmd.frame_load ? FRM_ENABLE : (r_frame + 3'd1);
        f_id    = ID_ENABLE;
        f_b0    = 8'h00;
        f_b1    = 8'h00;
        f_b2    = 8'h00;
        f_b3    = 8'h00;
        f_last  = 1'b0;
        unique case (n_frame)
            FRM_ENABLE: begin
                f_id = ID_ENABLE;
                f_b3 = 8'h01;
            end
            FRM_HYDR: begin
                f_id = ID_HYDR;
                f_b0 = 8'h01;
            end
            FRM_VALVE: begin
                f_id = ID_VALVE;
                f_b0 = 8'hB0;
                f_b1 = 8'h04;
            end
            FRM_LEFT: begin
                f_id = ID_LEFT;
                f_b0 = r_left_thr;
                f_b2 = {6'd0, r_left_dir};
            end
            FRM_RIGHT: begin
                f_id   = ID_RIGHT;
                f_b0   = r_right_thr;
                f_b2   = {6'd0, r_right_dir};
                f_last = 1'b1;
            end
            default: begin
                f_id = ID_ENABLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_lim <= 12'd500;
            r_half_sep  <= 12'd1293;
            r_max_turn  <= 15'd387;
            r_gain      <= 24'd32768;
            r_timeout   <= 16'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_LIM: r_speed_lim <= i_cfg_data[11:0];
                CFG_HALF_SEP:  r_half_sep  <= i_cfg_data[11:0];
                CFG_MAX_TURN:  r_max_turn  <= i_cfg_data[14:0];
                CFG_GAIN:      r_gain      <= i_cfg_data[23:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lin <= i_linear_mm_s;
            r_ang <= i_angular_mrad_s;
        end
        if (i_cmd.mix1) begin
            r_v    <= v_c[12:0];
            r_wneg <= w_c[16];
            r_prod <= {12'd0, w_abs[14:0]} * {15'd0, r_half_sep};
        end
        if (i_cmd.mix2) begin
            r_qe <= recip_prod[RECIP_SH +: 18];
        end
        if (i_cmd.mix3) begin
            r_vl <= v_x - d_s;
            r_vr <= v_x + d_s;
        end
        if (i_cmd.mul_l) begin
            r_pl <= mul_p;
        end
        if (i_cmd.mul_r) begin
            r_pr <= mul_p;
        end
        if (i_cmd.frame_load || i_cmd.frame_adv) begin
            r_frame  <= n_frame;
            r_can_id <= f_id;
            r_b0     <= f_b0;
            r_b1     <= f_b1;
            r_b2     <= f_b2;
            r_b3     <= f_b3;
            r_last   <= f_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_thr  <= 8'd0;
            r_left_dir  <= DIR_STOP;
            r_right_thr <= 8'd0;
            r_right_dir <= DIR_STOP;
            r_ticks     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_ticks     <= 16'd0;
                r_left_thr  <= thr_of(r_pl, (r_vl == 19'sd0));
                r_left_dir  <= dir_of(r_vl);
                r_right_thr <= thr_of(r_pr, (r_vr == 19'sd0));
                r_right_dir <= dir_of(r_vr);
            end
            if (i_cmd.tick) begin
                r_ticks <= n_ticks;
                if (n_ticks > r_timeout) begin
                    r_left_thr  <= 8'd0;
                    r_left_dir  <= DIR_STOP;
                    r_right_thr <= 8'd0;
                    r_right_dir <= DIR_STOP;
                end
            end
            if (i_cmd.frame_load) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_clear) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.taken = r_out_valid && !i_out_stall;
    assign o_stat.last  = (r_frame == FRM_RIGHT);

    assign o_out_valid  = r_out_valid;
    assign o_can_id     = r_can_id;
    assign o_data_byte0 = r_b0;
    assign o_data_byte1 = r_b1;
    assign o_data_byte2 = r_b2;
    assign o_data_byte3 = r_b3;
    assign o_last_frame = r_last;

endmodule
`default_nettype wire
